@@ design/sedfr_pkg.sv @@
// ---------------------------------------------------------------------------
// sedfr_pkg: shared types and constants
// Codes, field widths and status/phase types for the framed byte receiver.
// ---------------------------------------------------------------------------
package sedfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // longest data section before a frame is cut off as overlong
  localparam logic [POS_W-1:0] MAX_DATA_BYTES = POS_W'(256);
  localparam logic [POS_W-1:0] LAST_POS       = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_DATA   = 2'd2,
    PH_ESC    = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_GOOD      = 3'd1,
    ST_BAD       = 3'd2,
    ST_ABANDONED = 3'd3,
    ST_OVERLONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] escape_code;
  } codes_t;

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  position;
    status_t           status;
  } result_t;

endpackage

@@ design/sedfr_if.sv @@
// ---------------------------------------------------------------------------
// sedfr channel interfaces
// Valid/ready channels for received bytes and for frame buffer results.
// ---------------------------------------------------------------------------
interface sedfr_byte_if
  import sedfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sedfr_result_if
  import sedfr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   byte_out;
  logic [POS_W-1:0]    position;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output byte_out, output position, output status,
                  input ready);
  modport sink   (input valid, input byte_out, input position, input status,
                  output ready);
endinterface

@@ design/sedfr_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// sedfr_cfg_regs: framing code registers
// Holds start, end and escape codes; written through a plain write port.
// ---------------------------------------------------------------------------
module sedfr_cfg_regs
  import sedfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output codes_t               codes
);

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code  <= BYTE_W'(85);
      codes.end_code    <= BYTE_W'(4);
      codes.escape_code <= BYTE_W'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_CODE:  codes.start_code  <= cfg_data;
        REG_END_CODE:    codes.end_code    <= cfg_data;
        REG_ESCAPE_CODE: codes.escape_code <= cfg_data;
        default: ;  // unused index, ignored
      endcase
    end
  end

endmodule

@@ design/sedfr_frame_fsm.sv @@
// ---------------------------------------------------------------------------
// sedfr_frame_fsm: framing state machine
// Per-byte phase, checksum and buffer index update; builds one result.
// ---------------------------------------------------------------------------
module sedfr_frame_fsm
  import sedfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,      // staged byte is processed this cycle
  input  logic [BYTE_W-1:0] b,
  input  codes_t            codes,
  output result_t           res
);

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [POS_W-1:0]  write_index, write_index_next;
  logic [POS_W-1:0]  data_length, data_length_next;

  logic overlong;
  assign overlong = (data_length >= MAX_DATA_BYTES) || (write_index == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= '0;
      write_index <= '0;
      data_length <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      write_index <= write_index_next;
      data_length <= data_length_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    write_index_next = write_index;
    data_length_next = data_length;
    res.emit         = 1'b0;
    res.byte_out     = b;
    res.position     = write_index;
    res.status       = ST_STORED;

    case (phase)
      PH_HUNT: begin
        if (b == codes.start_code) begin
          res.emit         = 1'b1;
          res.position     = '0;
          write_index_next = POS_W'(1);
          phase_next       = PH_SECOND;
        end
      end
      PH_SECOND: begin
        res.emit = 1'b1;
        if (b != codes.start_code) begin
          res.status       = ST_ABANDONED;
          phase_next       = PH_HUNT;
          write_index_next = '0;
        end else begin
          running_sum_next = '0;
          data_length_next = '0;
          write_index_next = write_index + POS_W'(1);
          phase_next       = PH_DATA;
        end
      end
      PH_DATA: begin
        if (b == codes.start_code) begin
          // restart of the data section
          res.emit = 1'b1;
          if (write_index == LAST_POS) begin
            res.status       = ST_OVERLONG;
            phase_next       = PH_HUNT;
            write_index_next = '0;
          end else begin
            running_sum_next = '0;
            data_length_next = '0;
            write_index_next = write_index + POS_W'(1);
          end
        end else if (b == codes.end_code) begin
          res.emit         = 1'b1;
          res.status       = (running_sum == '0) ? ST_GOOD : ST_BAD;
          phase_next       = PH_HUNT;
          write_index_next = '0;
        end else if (b == codes.escape_code) begin
          phase_next = PH_ESC;
        end else begin
          res.emit = 1'b1;
          if (overlong) begin
            res.status       = ST_OVERLONG;
            phase_next       = PH_HUNT;
            write_index_next = '0;
          end else begin
            running_sum_next = running_sum + b;
            data_length_next = data_length + POS_W'(1);
            write_index_next = write_index + POS_W'(1);
          end
        end
      end
      default: begin
        // byte after escape: always literal data
        res.emit = 1'b1;
        if (overlong) begin
          res.status       = ST_OVERLONG;
          phase_next       = PH_HUNT;
          write_index_next = '0;
        end else begin
          running_sum_next = running_sum + b;
          data_length_next = data_length + POS_W'(1);
          write_index_next = write_index + POS_W'(1);
          phase_next       = PH_DATA;
        end
      end
    endcase
  end

endmodule

@@ design/stx_etx_dle_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// stx_etx_dle_frame_receiver: byte-stuffed frame receiver
// Start/end/escape framed bytes in, frame buffer writes and verdicts out.
// ---------------------------------------------------------------------------
// Usage:
//   rx     - sink channel, one received serial byte per request.
//   frame  - source channel; each request is a byte to store at a frame
//            buffer position (status 0), or a frame verdict: good (1),
//            checksum bad (2), abandoned after a bad second start (3),
//            overlong (4). Non-start bytes while hunting and escape codes
//            give no request.
//   cfg_*  - write port for start, end and escape codes (index 0, 1, 2);
//            write only while no byte is in flight.
// Path: an accepted byte passes the input register, then the result
//   register, before its result shows on frame.
// Throughput: one byte per cycle while frame.ready stays high; the framing
//   state update is a single compare/add step between the two registers.
// Reset (rst, synchronous): hunting for the first start code, checksum,
//   buffer index and data count cleared, codes back to 85/4/5, both
//   pipeline registers empty.
// Stall: while frame.ready is low and a result waits, the staged byte
//   holds; rx.ready stays high until the input register is also full.
// ---------------------------------------------------------------------------
module stx_etx_dle_frame_receiver
  import sedfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sedfr_byte_if.sink           rx,
  sedfr_result_if.source       frame,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  codes_t            codes;
  result_t           res;

  // input register
  logic              stg_valid;
  logic [BYTE_W-1:0] stg_byte;

  // result register has room this cycle
  logic              out_free;
  logic              step;

  assign out_free = !frame.valid || frame.ready;
  assign step     = stg_valid && out_free;
  assign rx.ready = !stg_valid || out_free;

  sedfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  sedfr_frame_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .b     (stg_byte),
    .codes (codes),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stg_valid <= 1'b1;
    end else if (out_free) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      stg_byte <= rx.rx_byte;
    end
  end

  // result register: loads whenever it has room; empty if nothing emitted
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (out_free) begin
      frame.valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      frame.byte_out <= res.byte_out;
      frame.position <= res.position;
      frame.status   <= res.status;
    end
  end

endmodule

@@ tb/stx_etx_dle_frame_receiver_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stx_etx_dle_frame_receiver_tb: self-checking bench for the framed receiver
// Drives received bytes through the rx channel and checks every frame buffer
// write and frame verdict against a cycle-free model of the framing rules.
// A short typed table opens the run. Random frames follow (good, bad sum,
// abandoned, cut short, restarted, overlong, buffer full, line noise) under
// several code settings, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module stx_etx_dle_frame_receiver_tb;
  import sedfr_pkg::*;

  // index past the three code registers; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam codes_t  RESET_CODES    = {8'd85, 8'd4, 8'd5};
  localparam result_t NO_RESULT      = '0;
  localparam int      PIPE_FLUSH     = 4;    // input reg + result reg, plus margin
  localparam int      WATCHDOG_LIMIT = 400;  // cycles with no request on any channel
  localparam int      ITEMS_PER_SET  = 330;
  // data bytes per section so that a two-section frame lands on the last slot
  localparam int      FULL_SECTION   = (int'(LAST_POS) - 3) / 2;

  typedef enum int {
    K_GOOD, K_BAD, K_ABANDON, K_TRUNC, K_RESTART, K_NOISE, K_OVERLONG, K_FULL
  } frame_kind_t;

  // one row of the opening table: the byte, and the request it must cause
  // when the row is typed; untyped rows go to the model
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              typed;
    result_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  sedfr_byte_if   rx_if ();
  sedfr_result_if frame_if ();

  stx_etx_dle_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .frame     (frame_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- framing model state --------------------------------------------------
  codes_t            cur_codes = RESET_CODES;
  phase_t            rx_phase  = PH_HUNT;
  logic [BYTE_W-1:0] chk_sum   = '0;
  logic [POS_W-1:0]  wr_idx    = '0;
  logic [POS_W-1:0]  data_cnt  = '0;

  result_t           frame_events [$];  // buffer writes and verdicts still due
  result_t           head;
  logic [BYTE_W-1:0] line_q [$];        // bytes of the frame being sent
  logic [BYTE_W-1:0] line_sum;          // literal data sum of that frame
  int                items_sent  = 0;
  int                err_cnt     = 0;
  int                quiet_cycles = 0;
  bit                steady      = 1'b0; // no idle bursts in the closing set

  // Directed opening, under the reset codes 0x55 / 0x04 / 0x05.
  dir_row_t dir_rows [23] = '{
    {8'h00, 1'b1, NO_RESULT},                               // hunting, ignored
    {8'hFF, 1'b1, NO_RESULT},
    {8'h55, 1'b1, {1'b1, 8'h55, 9'd0, ST_STORED}},          // first start
    {8'h55, 1'b1, {1'b1, 8'h55, 9'd1, ST_STORED}},          // second start
    {8'h01, 1'b0, NO_RESULT},
    {8'hFF, 1'b0, NO_RESULT},                               // sum wraps to zero
    {8'h04, 1'b1, {1'b1, 8'h04, 9'd4, ST_GOOD}},
    {8'h55, 1'b0, NO_RESULT},
    {8'h33, 1'b1, {1'b1, 8'h33, 9'd1, ST_ABANDONED}},       // bad second byte
    {8'h55, 1'b0, NO_RESULT},
    {8'h55, 1'b0, NO_RESULT},
    {8'h05, 1'b1, NO_RESULT},                               // escape dropped
    {8'h04, 1'b0, NO_RESULT},                               // escaped end is data
    {8'h05, 1'b0, NO_RESULT},
    {8'h55, 1'b0, NO_RESULT},                               // escaped start is data
    {8'h05, 1'b0, NO_RESULT},
    {8'h05, 1'b0, NO_RESULT},                               // escaped escape
    {8'h55, 1'b0, NO_RESULT},                               // restart, sum cleared
    {8'h01, 1'b0, NO_RESULT},
    {8'h04, 1'b1, {1'b1, 8'h04, 9'd7, ST_BAD}},
    {8'h55, 1'b0, NO_RESULT},
    {8'h55, 1'b0, NO_RESULT},
    {8'h04, 1'b1, {1'b1, 8'h04, 9'd2, ST_GOOD}}             // empty frame
  };

  // ---- framing model --------------------------------------------------------
  function automatic result_t store_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r.emit     = 1'b1;
    r.byte_out = b;
    r.position = wr_idx;
    r.status   = ST_STORED;
    wr_idx     = wr_idx + 1'b1;
    return r;
  endfunction

  // verdict or abort: report at the current slot, go back to hunting
  function automatic result_t close_frame(input logic [BYTE_W-1:0] b, input status_t st);
    result_t r;
    r.emit     = 1'b1;
    r.byte_out = b;
    r.position = wr_idx;
    r.status   = st;
    rx_phase   = PH_HUNT;
    wr_idx     = '0;
    return r;
  endfunction

  function automatic result_t take_data(input logic [BYTE_W-1:0] b);
    if (data_cnt >= MAX_DATA_BYTES || wr_idx == LAST_POS)
      return close_frame(b, ST_OVERLONG);
    chk_sum  = chk_sum + b;
    data_cnt = data_cnt + 1'b1;
    rx_phase = PH_DATA;
    return store_byte(b);
  endfunction

  // One received byte through the framing rules; emit is low when the byte
  // causes no request on the frame channel.
  function automatic result_t track_frame(input logic [BYTE_W-1:0] b);
    result_t r;
    r = NO_RESULT;
    case (rx_phase)
      PH_HUNT: begin
        if (b == cur_codes.start_code) begin
          wr_idx   = '0;
          rx_phase = PH_SECOND;
          r        = store_byte(b);
        end
      end
      PH_SECOND: begin
        if (b != cur_codes.start_code) begin
          r = close_frame(b, ST_ABANDONED);
        end else begin
          chk_sum  = '0;
          data_cnt = '0;
          rx_phase = PH_DATA;
          r        = store_byte(b);
        end
      end
      PH_DATA: begin
        // start beats end beats escape when codes coincide
        if (b == cur_codes.start_code) begin
          if (wr_idx == LAST_POS) begin
            r = close_frame(b, ST_OVERLONG);
          end else begin
            chk_sum  = '0;
            data_cnt = '0;
            r        = store_byte(b);
          end
        end else if (b == cur_codes.end_code) begin
          // negated sum is zero exactly when the sum is zero
          r = close_frame(b, (chk_sum == '0) ? ST_GOOD : ST_BAD);
        end else if (b == cur_codes.escape_code) begin
          rx_phase = PH_ESC;
        end else begin
          r = take_data(b);
        end
      end
      default: r = take_data(b);  // byte after an escape is always data
    endcase
    return r;
  endfunction

  function automatic void set_code(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] v);
    case (idx)
      REG_START_CODE:  cur_codes.start_code  = v;
      REG_END_CODE:    cur_codes.end_code    = v;
      REG_ESCAPE_CODE: cur_codes.escape_code = v;
      default: ;
    endcase
  endfunction

  // ---- frame building -------------------------------------------------------
  function automatic bit is_code(input logic [BYTE_W-1:0] b);
    return b == cur_codes.start_code || b == cur_codes.end_code ||
           b == cur_codes.escape_code;
  endfunction

  // biased toward the codes so escaping gets plenty of traffic
  function automatic logic [BYTE_W-1:0] any_byte();
    case ($urandom_range(0, 11))
      0:       return cur_codes.start_code;
      1:       return cur_codes.end_code;
      2:       return cur_codes.escape_code;
      default: return 8'($urandom);
    endcase
  endfunction

  // Literal data byte onto the line. When the escape code can never be seen
  // as an escape (it equals start or end), code values are nudged away.
  function automatic void push_data(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] lit;
    logic              can_esc;
    lit     = b;
    can_esc = cur_codes.escape_code != cur_codes.start_code &&
              cur_codes.escape_code != cur_codes.end_code;
    if (is_code(lit)) begin
      if (can_esc)
        line_q.push_back(cur_codes.escape_code);
      else
        while (is_code(lit)) lit = lit + 8'd1;
    end
    line_q.push_back(lit);
    line_sum = line_sum + lit;
  endfunction

  // ---- mismatch reporting ---------------------------------------------------
  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("%0t ns frame mismatch: %s", $time, what);
  endtask

  // ---- rx side --------------------------------------------------------------
  // Called at a falling edge. Optionally idles first, then holds the
  // request until it is taken; the model sees the byte at that same edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input result_t typed_want);
    result_t r;
    if (!steady && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    r = track_frame(b);
    if (typed)
      r = typed_want;
    if (r.emit)
      frame_events.push_back(r);
    @(negedge clk);
  endtask

  // Stop sending and let the block drain. Bytes that cause no request may
  // still be in the pipe when the last request shows, hence the flush.
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (frame_events.size() != 0) @(negedge clk);
    repeat (PIPE_FLUSH) @(negedge clk);
  endtask

  task automatic load_codes(input codes_t c, input bit poke_spare);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [BYTE_W-1:0]    vals [4];
    int                   n;
    regs = '{REG_START_CODE, REG_END_CODE, REG_ESCAPE_CODE, REG_SPARE};
    vals = '{c.start_code, c.end_code, c.escape_code, 8'($urandom)};
    n    = poke_spare ? 4 : 3;
    settle();
    cfg_we <= 1'b1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      set_code(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [BYTE_W-1:0] b;
    int                n;
    line_q.delete();
    line_sum = '0;
    // mostly short frames, now and then a longer one
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (kind == K_NOISE) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
    end else begin
      line_q.push_back(cur_codes.start_code);
      if (kind == K_ABANDON) begin
        b = 8'($urandom);
        if (b == cur_codes.start_code)
          b = ~b;
        line_q.push_back(b);
      end else begin
        line_q.push_back(cur_codes.start_code);
        case (kind)
          K_OVERLONG: n = $urandom_range(int'(MAX_DATA_BYTES) - 1, int'(MAX_DATA_BYTES) + 1);
          K_RESTART: begin
            repeat (n) push_data(any_byte());
            line_q.push_back(cur_codes.start_code);
            line_sum = '0;
            n = $urandom_range(0, 8);
          end
          K_FULL: begin
            // two sections fill the buffer up to the last slot; the byte
            // that lands there is either a restart or plain data
            repeat (FULL_SECTION) push_data(any_byte());
            line_q.push_back(cur_codes.start_code);
            repeat (FULL_SECTION) push_data(any_byte());
            if ($urandom_range(0, 1) == 0)
              line_q.push_back(cur_codes.start_code);
            else
              push_data(any_byte());
            n = 0;
          end
          default: ;
        endcase
        repeat (n) push_data(any_byte());
        if (kind == K_BAD)
          push_data(8'(8'd0 - line_sum + 8'($urandom_range(1, 255))));
        else if (kind != K_TRUNC && kind != K_FULL)
          push_data(8'(8'd0 - line_sum));
        if (kind != K_TRUNC)
          line_q.push_back(cur_codes.end_code);
      end
    end
    if (kind != K_NOISE)
      items_sent += line_q.size();
    foreach (line_q[i]) send_byte(line_q[i], 1'b0, NO_RESULT);
  endtask

  // ---- frame side: random stalls ---------------------------------------------
  initial begin : frame_sink
    int stall_left;
    stall_left     = 0;
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        frame_if.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);  // random stall burst
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= 1'b1;
      end
    end
  end

  // ---- frame side: checking ----------------------------------------------------
  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready) begin
      if (frame_events.size() == 0) begin
        report_mismatch($sformatf("unexpected request byte %02h pos %0d status %0d",
                                  frame_if.byte_out, frame_if.position, frame_if.status));
      end else begin
        head = frame_events.pop_front();
        if (frame_if.byte_out !== head.byte_out)
          report_mismatch($sformatf("byte_out %02h, expected %02h",
                                    frame_if.byte_out, head.byte_out));
        if (frame_if.position !== head.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    frame_if.position, head.position));
        if (frame_if.status !== head.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    frame_if.status, head.status));
      end
    end
  end

  // ---- watchdog: no request on either channel for too long ------------------
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("watchdog: no request for %0d cycles, %0d requests still due",
               WATCHDOG_LIMIT, frame_events.size());
      $display("stx_etx_dle_frame_receiver_tb: errors");
      $finish;
    end
  end

  // ---- stimulus ---------------------------------------------------------------
  initial begin : stimulus
    codes_t      code_sets [6];
    codes_t      next_codes;
    frame_kind_t kind;
    int          goal;
    int          pick;
    bit          paused;

    // Code settings: extremes, start == escape (escape unreachable),
    // end == escape, all three equal, random, and back to the reset values.
    code_sets = '{{8'h00, 8'hFF, 8'h80}, {8'hFF, 8'h00, 8'hFF}, {8'h3C, 8'hA5, 8'hA5},
                  {8'h07, 8'h07, 8'h07}, RESET_CODES, RESET_CODES};
    paused        = 1'b0;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_START_CODE;
    cfg_data      = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // typed opening under the reset codes
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx_byte, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      next_codes = code_sets[p];
      if (p == 4)
        next_codes = codes_t'($urandom);
      steady = (p == 5);         // closing set runs with no idle bursts
      load_codes(next_codes, p == 5);
      goal = items_sent + ITEMS_PER_SET;
      if (p == 0) begin
        // distinct codes here, so both long frames keep their shape
        send_frame(K_FULL);
        send_frame(K_OVERLONG);
      end
      while (items_sent < goal) begin
        pick = $urandom_range(0, 199);
        if (pick < 90)       kind = K_GOOD;
        else if (pick < 116) kind = K_BAD;
        else if (pick < 132) kind = K_ABANDON;
        else if (pick < 144) kind = K_TRUNC;
        else if (pick < 164) kind = K_RESTART;
        else if (pick < 196) kind = K_NOISE;
        else if (pick < 198) kind = K_OVERLONG;
        else                 kind = K_FULL;
        send_frame(kind);
        // hold the line mid-set until every due request is out
        if (p == 2 && !paused && items_sent > goal - ITEMS_PER_SET / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (err_cnt == 0)
      $display("stx_etx_dle_frame_receiver_tb: clean");
    else
      $display("stx_etx_dle_frame_receiver_tb: errors");
    $finish;
  end

endmodule
